>>> hw/rtl/aba_pkg.sv
// Package for the arena block allocator: types, codes and defaults.
package aba_pkg;

  localparam int unsigned MaxEntriesDefault  = 64;
  localparam int unsigned MinAlignDefault    = 16;
  localparam int unsigned HeaderBytesDefault = 32;

  localparam logic [31:0] CapacityReset = 32'd65536;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_UNMATCHED = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_POOL_MODE = 1'd0,
    CFG_CAPACITY  = 1'd1
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_APPEND,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] req_size;
    logic [12:0] req_align;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_offset;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;
    logic [31:0] live_allocs;
  } rsp_t;

endpackage

>>> hw/rtl/arena_block_allocator.sv
// Arena block allocator top level: sequencer, block table and counters.
//
// Serves allocate, free and reset requests against an arena of capacity_q
// bytes. A bump mode (pool_mode 1) request passes through accept, check and
// result load. In block mode an allocate or free walks the block table one
// entry per cycle through a single registered read port. A hit ends the
// walk. An unmatched free walks every entry, and an allocate that finds no
// fitting free block goes on to the append step after the full walk. One
// request is in flight at a time. The result is loaded into an output
// register. The next request can be taken while that result waits.
// A finished request holds in its last cycle while the previous result is
// still stalled. The table needs no clearing after reset.
module arena_block_allocator #(
  parameter int unsigned MAX_ENTRIES  = aba_pkg::MaxEntriesDefault,
  parameter int unsigned MIN_ALIGN    = aba_pkg::MinAlignDefault,
  parameter int unsigned HEADER_BYTES = aba_pkg::HeaderBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  aba_pkg::req_t  req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output aba_pkg::rsp_t  rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);
  localparam logic [32:0] MinAl = 33'(MIN_ALIGN);
  localparam logic [32:0] Hdr   = 33'(HEADER_BYTES);

  aba_pkg::state_e state_q, state_d;

  // Configuration registers
  logic        pool_mode_q;
  logic [31:0] capacity_q;

  // Counters
  logic [31:0] head_q, used_q, peak_q, allocs_q;
  logic [CntW-1:0] total_q;

  // Request registers
  aba_pkg::req_t req_q;
  logic [32:0] align_q;        // effective alignment
  logic [CntW-1:0] scan_q;     // entry being read
  logic [CntW-1:0] scan_prev;  // entry whose data is registered
  logic        rd_pend_q;      // read data valid for entry scan_q - 1
  aba_pkg::status_e st_q;      // status of the request in flight
  logic [31:0] off_q;          // offset of the request in flight

  aba_pkg::rsp_t rsp_q;
  logic          rsp_valid_q;

  // Alignment arithmetic
  logic [32:0] a_m1, append_hdr, append_total;
  logic [33:0] append_end, bump_end;
  logic [32:0] bump_at, reuse_off;
  logic [32:0] used_sum;
  logic [31:0] used_sat;

  // Block table: one memory per field, read data registered
  logic [31:0] mem_start [MAX_ENTRIES];
  logic [31:0] mem_bytes [MAX_ENTRIES];
  logic [31:0] mem_span  [MAX_ENTRIES];
  logic        mem_busy  [MAX_ENTRIES];
  logic [31:0] rd_start_q, rd_bytes_q, rd_span_q;
  logic        rd_busy_q;

  // Memory control
  logic            wr_en, busy_wr_en, busy_wr_val;
  logic [IdxW-1:0] wr_idx, busy_idx, rd_idx;

  assign rd_idx    = scan_q[IdxW-1:0];
  assign scan_prev = scan_q - CntW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[wr_idx] <= head_q;
      mem_bytes[wr_idx] <= req_q.req_size;
      mem_span[wr_idx]  <= append_total[31:0];
    end
    if (busy_wr_en) begin
      mem_busy[busy_idx] <= busy_wr_val;
    end
    rd_start_q <= mem_start[rd_idx];
    rd_bytes_q <= mem_bytes[rd_idx];
    rd_span_q  <= mem_span[rd_idx];
    rd_busy_q  <= mem_busy[rd_idx];
  end

  assign a_m1         = align_q - 33'd1;
  assign append_hdr   = (Hdr + a_m1) & ~a_m1;
  assign append_total = append_hdr + {1'b0, req_q.req_size};
  assign append_end   = {2'b0, head_q} + {1'b0, append_total};
  assign bump_at      = ({1'b0, head_q} + a_m1) & ~a_m1;
  assign bump_end     = {1'b0, bump_at} + {2'b0, req_q.req_size};
  assign reuse_off    = ({1'b0, rd_start_q} + Hdr + a_m1) & ~a_m1;

  // Saturating add of the operand to the used count
  logic [31:0] add_op;
  assign used_sum = {1'b0, used_q} + {1'b0, add_op};
  assign used_sat = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];

  // Scan compares on the registered entry
  logic        alloc_hit, free_hit, rd_ok;
  logic [32:0] span_end;
  assign rd_ok     = rd_pend_q;
  assign span_end  = {1'b0, rd_start_q} + {1'b0, rd_span_q};
  assign alloc_hit = rd_ok && !rd_busy_q && (rd_bytes_q >= req_q.req_size);
  assign free_hit  = rd_ok && rd_busy_q && (req_q.free_offset >= rd_start_q)
                   && ({1'b0, req_q.free_offset} < span_end);

  logic req_acc, is_alloc, is_free;
  assign req_acc  = req_valid_i && !req_stall_o;
  assign is_alloc = req_q.req_type == aba_pkg::REQ_ALLOC;
  assign is_free  = req_q.req_type == aba_pkg::REQ_FREE;

  // Effective alignment of an incoming request
  logic [32:0] in_align;
  always_comb begin
    in_align = {20'd0, req_i.req_align};
    if (req_i.req_align == 13'd0 || (req_i.req_align & (req_i.req_align - 13'd1)) != 13'd0
        || in_align < MinAl) begin
      in_align = MinAl;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      aba_pkg::S_IDLE:   if (req_acc) state_d = aba_pkg::S_CHECK;
      aba_pkg::S_CHECK: begin
        if (is_alloc && req_q.req_size != 32'd0 && !pool_mode_q) state_d = aba_pkg::S_SCAN;
        else if (is_free && !pool_mode_q) state_d = aba_pkg::S_SCAN;
        else state_d = aba_pkg::S_DONE;
      end
      aba_pkg::S_SCAN: begin
        if ((is_alloc && alloc_hit) || (is_free && free_hit)) state_d = aba_pkg::S_DONE;
        else if (!rd_ok && scan_q >= total_q)
          state_d = is_alloc ? aba_pkg::S_APPEND : aba_pkg::S_DONE;
      end
      aba_pkg::S_APPEND: state_d = aba_pkg::S_DONE;
      aba_pkg::S_DONE:   if (!rsp_valid_q || !rsp_stall_i) state_d = aba_pkg::S_IDLE;
      default:           state_d = aba_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall_o = state_q != aba_pkg::S_IDLE;
    cfg_ready_o = state_q == aba_pkg::S_IDLE;
    wr_en       = 1'b0;
    wr_idx      = total_q[IdxW-1:0];
    busy_wr_en  = 1'b0;
    busy_wr_val = 1'b1;
    busy_idx    = total_q[IdxW-1:0];
    add_op      = req_q.req_size;
    case (state_q)
      aba_pkg::S_SCAN: begin
        add_op   = rd_bytes_q;
        busy_idx = scan_prev[IdxW-1:0];
        if (is_alloc && alloc_hit) begin
          busy_wr_en = 1'b1;
        end else if (is_free && free_hit) begin
          busy_wr_en  = 1'b1;
          busy_wr_val = 1'b0;
        end
      end
      aba_pkg::S_APPEND: begin
        if (append_end <= {2'b0, capacity_q} && total_q < MaxCnt) begin
          wr_en      = 1'b1;
          busy_wr_en = 1'b1;
          busy_idx   = total_q[IdxW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aba_pkg::S_IDLE;
      pool_mode_q <= 1'b1;
      capacity_q  <= aba_pkg::CapacityReset;
      head_q      <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      allocs_q    <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      // Output register: load a finished result, drop it once taken
      if (state_q == aba_pkg::S_DONE && (!rsp_valid_q || !rsp_stall_i)) begin
        rsp_valid_q         <= 1'b1;
        rsp_q.status        <= st_q;
        rsp_q.result_offset <= off_q;
        rsp_q.used_bytes    <= used_q;
        rsp_q.peak_bytes    <= peak_q;
        rsp_q.live_allocs   <= allocs_q;
      end else if (rsp_valid_q && !rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
      // Configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == aba_pkg::CFG_POOL_MODE) pool_mode_q <= cfg_data_i[0];
        else capacity_q <= cfg_data_i;
      end
      case (state_q)
        aba_pkg::S_IDLE: begin
          if (req_acc) begin
            req_q     <= req_i;
            align_q   <= in_align;
            st_q      <= aba_pkg::ST_OK;
            off_q     <= '0;
            scan_q    <= '0;
            rd_pend_q <= 1'b0;
          end
        end
        aba_pkg::S_CHECK: begin
          if (is_alloc) begin
            if (req_q.req_size == 32'd0) begin
              st_q <= aba_pkg::ST_ZERO_SIZE;
            end else if (pool_mode_q) begin
              if (bump_end > {2'b0, capacity_q}) begin
                st_q <= aba_pkg::ST_NO_SPACE;
              end else begin
                head_q   <= bump_end[31:0];
                used_q   <= bump_end[31:0];
                if (bump_end[31:0] > peak_q) peak_q <= bump_end[31:0];
                allocs_q <= allocs_q + 32'd1;
                off_q    <= bump_at[31:0];
              end
            end
          end else if (req_q.req_type == aba_pkg::REQ_RESET && pool_mode_q) begin
            head_q   <= '0;
            used_q   <= '0;
            allocs_q <= '0;
          end
          if (!pool_mode_q) begin
            scan_q    <= CntW'(1);
            rd_pend_q <= total_q != '0;
          end
        end
        aba_pkg::S_SCAN: begin
          if (is_alloc && alloc_hit) begin
            allocs_q <= allocs_q + 32'd1;
            used_q   <= used_sat;
            if (used_sat > peak_q) peak_q <= used_sat;
            off_q    <= reuse_off[31:0];
          end else if (is_free && free_hit) begin
            allocs_q <= allocs_q - 32'd1;
            if (used_q >= rd_bytes_q) used_q <= used_q - rd_bytes_q;
          end else if (!rd_ok && scan_q >= total_q) begin
            if (is_free) st_q <= aba_pkg::ST_UNMATCHED;
          end else begin
            rd_pend_q <= scan_q < total_q;
            if (scan_q < total_q) scan_q <= scan_q + CntW'(1);
          end
        end
        aba_pkg::S_APPEND: begin
          if (append_end > {2'b0, capacity_q}) begin
            st_q <= aba_pkg::ST_NO_SPACE;
          end else if (total_q >= MaxCnt) begin
            st_q <= aba_pkg::ST_TABLE_FULL;
          end else begin
            total_q  <= total_q + CntW'(1);
            head_q   <= append_end[31:0];
            used_q   <= used_sat;
            if (used_sat > peak_q) peak_q <= used_sat;
            allocs_q <= allocs_q + 32'd1;
            off_q    <= 32'(({1'b0, head_q}) + append_hdr);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> tb/sv/arena_block_allocator_checker.sv
// Checker for the arena block allocator: predicts every response and compares it.
`timescale 1ns / 100ps

module arena_block_allocator_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_stall_i,
  input  aba_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_stall_i,
  input  aba_pkg::rsp_t rsp_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output int            err_count_o,
  output int            pending_o
);

  localparam int Entries = int'(aba_pkg::MaxEntriesDefault);
  localparam logic [63:0] MinAlign = 64'(aba_pkg::MinAlignDefault);
  localparam logic [63:0] HdrBytes = 64'(aba_pkg::HeaderBytesDefault);
  localparam logic [63:0] Max32 = 64'hFFFF_FFFF;

  // Shadow copy of the allocator state
  logic        pool_mode;
  logic [31:0] capacity;
  logic [31:0] head;
  logic [31:0] used;
  logic [31:0] peak;
  logic [31:0] live;
  logic [31:0] blk_start [Entries];
  logic [31:0] blk_bytes [Entries];
  logic [31:0] blk_span  [Entries];
  logic        blk_busy  [Entries];
  int          blk_count;

  aba_pkg::rsp_t expected_rsp_q[$];
  int   errors;

  assign err_count_o = errors;
  assign pending_o   = expected_rsp_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
  endtask

  function automatic logic [63:0] round_up(input logic [63:0] x, input logic [63:0] a);
    return (x + a - 64'd1) & ~(a - 64'd1);
  endfunction

  task automatic add_used(input logic [63:0] n);
    logic [63:0] s;
    s = {32'd0, used} + n;
    used = (s > Max32) ? Max32[31:0] : s[31:0];
    if (used > peak) peak = used;
  endtask

  // Allocate: bump placement, or first-fit reuse then append in block mode
  task automatic do_alloc(input aba_pkg::req_t r, output aba_pkg::status_e st,
                          output logic [31:0] off);
    logic [63:0] a;
    logic [63:0] at;
    logic [63:0] hdr;
    logic [63:0] total;
    bit          done;
    st   = aba_pkg::ST_OK;
    off  = '0;
    done = 0;
    a = {51'd0, r.req_align};
    if (a == 0 || (a & (a - 1)) != 0 || a < MinAlign) a = MinAlign;
    if (r.req_size == 0) begin
      st = aba_pkg::ST_ZERO_SIZE;
    end else if (pool_mode) begin
      at = round_up({32'd0, head}, a);
      if (at + {32'd0, r.req_size} > {32'd0, capacity}) begin
        st = aba_pkg::ST_NO_SPACE;
      end else begin
        head = 32'(at + {32'd0, r.req_size});
        used = head;
        if (used > peak) peak = used;
        live++;
        off = at[31:0];
      end
    end else begin
      for (int i = 0; i < blk_count && !done; i++) begin
        if (!blk_busy[i] && blk_bytes[i] >= r.req_size) begin
          blk_busy[i] = 1'b1;
          live++;
          add_used({32'd0, blk_bytes[i]});
          at   = round_up({32'd0, blk_start[i]} + HdrBytes, a);
          off  = at[31:0];
          done = 1;
        end
      end
      if (!done) begin
        hdr   = round_up(HdrBytes, a);
        total = hdr + {32'd0, r.req_size};
        if ({32'd0, head} + total > {32'd0, capacity}) begin
          st = aba_pkg::ST_NO_SPACE;
        end else if (blk_count >= Entries) begin
          st = aba_pkg::ST_TABLE_FULL;
        end else begin
          blk_start[blk_count] = head;
          blk_bytes[blk_count] = r.req_size;
          blk_span[blk_count]  = total[31:0];
          blk_busy[blk_count]  = 1'b1;
          blk_count++;
          off  = head + hdr[31:0];
          head = head + total[31:0];
          add_used({32'd0, r.req_size});
          live++;
        end
      end
    end
  endtask

  // Free: first busy block whose span covers the offset, no effect in bump mode
  task automatic do_free(input logic [31:0] p, output aba_pkg::status_e st);
    logic [63:0] e;
    bit          done;
    done = 0;
    st   = aba_pkg::ST_OK;
    if (!pool_mode) begin
      st = aba_pkg::ST_UNMATCHED;
      for (int i = 0; i < blk_count && !done; i++) begin
        e = {32'd0, blk_start[i]} + {32'd0, blk_span[i]};
        if (p >= blk_start[i] && {32'd0, p} < e && blk_busy[i]) begin
          blk_busy[i] = 1'b0;
          live--;
          if (used >= blk_bytes[i]) used -= blk_bytes[i];
          st   = aba_pkg::ST_OK;
          done = 1;
        end
      end
    end
  endtask

  task automatic serve(input aba_pkg::req_t r, output aba_pkg::rsp_t o);
    aba_pkg::status_e st;
    logic [31:0]      off;
    st  = aba_pkg::ST_OK;
    off = '0;
    case (r.req_type)
      aba_pkg::REQ_ALLOC: do_alloc(r, st, off);
      aba_pkg::REQ_FREE:  do_free(r.free_offset, st);
      aba_pkg::REQ_RESET: begin
        if (pool_mode) begin
          head = '0;
          used = '0;
          live = '0;
        end
      end
      default: ;
    endcase
    o.status        = st;
    o.result_offset = (st == aba_pkg::ST_OK) ? off : '0;
    o.used_bytes    = used;
    o.peak_bytes    = peak;
    o.live_allocs   = live;
  endtask

  // Watch all three channels; compare before queuing the next expectation
  always @(posedge clk_i or negedge rst_ni) begin
    aba_pkg::rsp_t want;
    aba_pkg::rsp_t got;
    if (!rst_ni) begin
      pool_mode = 1'b1;
      capacity  = aba_pkg::CapacityReset;
      head      = '0;
      used      = '0;
      peak      = '0;
      live      = '0;
      blk_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        got = rsp_i;
        if (expected_rsp_q.size() == 0) begin
          report("unexpected response, status", {29'd0, got.status}, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.status != want.status)
            report("status", {29'd0, got.status}, {29'd0, want.status});
          if (got.result_offset != want.result_offset)
            report("result_offset", got.result_offset, want.result_offset);
          if (got.used_bytes != want.used_bytes)
            report("used_bytes", got.used_bytes, want.used_bytes);
          if (got.peak_bytes != want.peak_bytes)
            report("peak_bytes", got.peak_bytes, want.peak_bytes);
          if (got.live_allocs != want.live_allocs)
            report("live_allocs", got.live_allocs, want.live_allocs);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == aba_pkg::CFG_POOL_MODE) pool_mode = cfg_data_i[0];
        else capacity = cfg_data_i;
      end
      if (req_valid_i && !req_stall_i) begin
        serve(req_i, want);
        expected_rsp_q.push_back(want);
      end
    end
  end

  initial errors = 0;

endmodule

>>> tb/sv/arena_block_allocator_tb.sv
// Testbench top for the arena block allocator: stimulus, config phases and verdict.
`timescale 1ns / 100ps

module arena_block_allocator_tb;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          req_valid_i = 1'b0;
  logic          req_stall_o;
  aba_pkg::req_t req_i = '0;
  logic          rsp_valid_o;
  logic          rsp_stall_i = 1'b0;
  aba_pkg::rsp_t rsp_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic          cfg_index_i = 1'b0;
  logic [31:0]   cfg_data_i = '0;

  int err_count;
  int pending;
  int n_alloc, n_free, n_other;
  bit no_idle;
  int stall_left;

  always #1 clk_i = ~clk_i;

  arena_block_allocator dut (.*);

  arena_block_allocator_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_stall_i, .rsp_i(rsp_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // response-side stall pattern
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      rsp_stall_i <= !no_idle && ($urandom_range(0, 2) == 0);
      stall_left  <= pick_gap();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic send(input aba_pkg::req_type_e t, input logic [31:0] size,
                      input logic [12:0] align, input logic [31:0] foff);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i         <= 1'b1;
    req_i.req_type      <= t;
    req_i.req_size      <= size;
    req_i.req_align     <= align;
    req_i.free_offset   <= foff;
    if (t == aba_pkg::REQ_ALLOC) n_alloc++;
    else if (t == aba_pkg::REQ_FREE) n_free++;
    else n_other++;
    forever begin
      @(posedge clk_i);
      if (!req_stall_o) break;
    end
  endtask

  // register write, only once every response is back
  task automatic write_cfg(input aba_pkg::cfg_index_e idx, input logic [31:0] data);
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [12:0] rand_align();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 13'd1 << $urandom_range(0, 12);
    if (r < 8) return 13'd0;
    return 13'($urandom);
  endfunction

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return 32'd0;
    if (r < 4) return $urandom_range(1, 8192);
    return $urandom_range(1, 256);
  endfunction

  // well-formed alloc/free mix with some noise
  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send(aba_pkg::REQ_ALLOC, rand_size(), rand_align(), $urandom);
      else if (r < 85)
        send(aba_pkg::REQ_FREE, $urandom, rand_align(), $urandom_range(0, 12000));
      else if (r < 90) send(aba_pkg::REQ_FREE, $urandom, 13'($urandom), $urandom);
      else if (r < 96) send(aba_pkg::REQ_RESET, $urandom, 13'($urandom), $urandom);
      else send(aba_pkg::req_type_e'(2'd3), $urandom, 13'($urandom), $urandom);
    end
  endtask

  initial begin
    stall_left = 0;
    no_idle = 0;
    n_alloc = 0;
    n_free = 0;
    n_other = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bump mode at reset defaults
    send(aba_pkg::REQ_ALLOC, 32'd1, 13'd0, '0);
    send(aba_pkg::REQ_ALLOC, 32'd100, 13'd4096, '0);
    send(aba_pkg::REQ_ALLOC, 32'd5, 13'd3, '0);
    send(aba_pkg::REQ_ALLOC, 32'd5, 13'd8, '0);
    send(aba_pkg::REQ_ALLOC, 32'd7, 13'h1FFF, '0);
    send(aba_pkg::REQ_ALLOC, 32'd0, 13'd16, '0);
    send(aba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 13'd16, '0);
    send(aba_pkg::REQ_FREE, '0, '0, 32'd4096);
    send(aba_pkg::REQ_RESET, '0, '0, '0);
    send(aba_pkg::req_type_e'(2'd3), 32'hFFFF_FFFF, 13'h1FFF, 32'hFFFF_FFFF);
    send(aba_pkg::REQ_ALLOC, 32'd64, 13'd32, '0);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'd1);
    send(aba_pkg::REQ_ALLOC, 32'd1, 13'd0, '0);
    send(aba_pkg::REQ_RESET, '0, '0, '0);
    send(aba_pkg::REQ_ALLOC, 32'd1, 13'd0, '0);
    send(aba_pkg::REQ_ALLOC, 32'd1, 13'd0, '0);

    // directed: block mode, reuse, unmatched free, reset ignored
    write_cfg(aba_pkg::CFG_POOL_MODE, 32'd0);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
    send(aba_pkg::REQ_ALLOC, 32'd100, 13'd64, '0);
    send(aba_pkg::REQ_ALLOC, 32'd40, 13'd0, '0);
    send(aba_pkg::REQ_FREE, '0, '0, 32'd10);
    send(aba_pkg::REQ_ALLOC, 32'd50, 13'd4096, '0);
    send(aba_pkg::REQ_FREE, '0, '0, 32'd10);
    send(aba_pkg::REQ_FREE, '0, '0, 32'd10);
    send(aba_pkg::REQ_RESET, '0, '0, '0);
    send(aba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 13'd16, '0);
    send(aba_pkg::REQ_ALLOC, 32'h8000_0000, 13'd16, '0);

    // random phases over several settings
    random_phase(150);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'd65536);
    no_idle = 1;
    random_phase(120);
    no_idle = 0;
    write_cfg(aba_pkg::CFG_POOL_MODE, 32'd1);
    write_cfg(aba_pkg::CFG_CAPACITY, $urandom_range(1000, 200000));
    random_phase(150);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
    random_phase(130);
    write_cfg(aba_pkg::CFG_POOL_MODE, 32'd0);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'd1);
    random_phase(60);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'hFFFF_FFFF);
    random_phase(150);
    write_cfg(aba_pkg::CFG_POOL_MODE, 32'd1);
    write_cfg(aba_pkg::CFG_CAPACITY, 32'd65536);
    no_idle = 1;
    random_phase(160);
    no_idle = 0;

    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("covered %0d allocates, %0d frees, %0d resets or other requests",
             n_alloc, n_free, n_other);
    $display("both pool modes, capacities from 1 byte to 4 GiB, random stalls on both sides");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #4ms;
    $display("timeout with %0d responses outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
